// File: rtl/polygon_point_locator_unit_defines.svh
// Assertion macros used by the port-level checker
`ifndef POLYGON_POINT_LOCATOR_UNIT_DEFINES_SVH
`define POLYGON_POINT_LOCATOR_UNIT_DEFINES_SVH

// Concurrent assertion clocked on clk, disabled in reset
`define PPL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion clocked on clk, active during reset as well
`define PPL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ppl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppl_pkg
// Types, constants and codes of the polygon point locator.
// ----------------------------------------------------------------------------
package ppl_pkg;
  localparam int MAX_EDGES_DEF   = 256;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int FIELD_W = 16;
  localparam int TOL_W   = 16;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  localparam logic [1:0] LOC_OUTSIDE = 2'd0;
  localparam logic [1:0] LOC_INSIDE  = 2'd1;
  localparam logic [1:0] LOC_ON_WALL = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [FIELD_W-1:0] edge_start_x;
    logic [FIELD_W-1:0] edge_start_y;
    logic [FIELD_W-1:0] edge_end_x;
    logic [FIELD_W-1:0] edge_end_y;
    logic [FIELD_W-1:0] query_x;
    logic [FIELD_W-1:0] query_y;
  } ppl_req_t;

  typedef struct packed {
    logic [1:0] location;
    logic [7:0] nearest_edge;
    logic [8:0] edges_held;
    logic [1:0] status;
  } ppl_rsp_t;
endpackage

// File: rtl/ppl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppl_req_if / ppl_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface ppl_req_if import ppl_pkg::*; ();
  logic     valid;
  logic     ready;
  ppl_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ppl_rsp_if import ppl_pkg::*; ();
  logic     valid;
  logic     ready;
  ppl_rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/polygon_point_locator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_point_locator_unit
// Even-odd point location and nearest wall search over a segment table.
// ----------------------------------------------------------------------------
// channel | dir | handshake        | content
// in      | in  | valid/ready      | action, edge end points, query point
// out     | out | valid/ready      | location, nearest_edge, edges_held, status
// cfg     | in  | cfg_we/cfg_wdata | wall_tolerance_sq
//
// Clear, load and a query on an empty table go straight to the result. A query
// reads each held edge in turn: differences, products on one shared multiplier,
// then, when the foot point falls strictly between the edge's ends, one restoring
// divider step per cycle, and last the update of the result.
// Reset (rst_n, synchronous) empties the table; entries are never cleared.
// A result waiting on out.ready holds the block; no request is taken then.
module polygon_point_locator_unit
  import ppl_pkg::*;
#(
  parameter int MAX_EDGES   = MAX_EDGES_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input logic              clk,
  input logic              rst_n,
  ppl_req_if.sink          in_ch,
  ppl_rsp_if.source        out_ch,
  input logic              cfg_we,
  input logic [TOL_W-1:0]  cfg_wdata
);
  localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW  = $clog2(MAX_EDGES + 1);
  localparam int DW  = COORD_WIDTH + 1;       // differences
  localparam int PW  = 2 * DW;                // products
  localparam int SW  = PW + 1;                // sums of two products
  localparam int MW  = SW - 1;                // magnitude of a sum
  localparam int QW  = 2 * SW;                // cross squared
  localparam int CNT = $clog2(QW + 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_RD    = 12'b000000000010,
    S_DIFF  = 12'b000000000100,
    S_M0    = 12'b000000001000,
    S_M1    = 12'b000000010000,
    S_M2    = 12'b000000100000,
    S_M3    = 12'b000001000000,
    S_M4    = 12'b000010000000,
    S_M5    = 12'b000100000000,
    S_DIV   = 12'b001000000000,
    S_EVAL  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [4*COORD_WIDTH-1:0] mem [MAX_EDGES];
  logic [4*COORD_WIDTH-1:0] rd_r;
  logic [CW-1:0]  count_r;
  logic [AW-1:0]  idx_r;
  logic [TOL_W-1:0] tol_r;
  logic signed [COORD_WIDTH-1:0] px_r, py_r;
  logic signed [DW-1:0] dx_r, dy_r, ux_r, uy_r, vx_r, vy_r;
  logic signed [DW-1:0] mul_a, mul_b;
  logic [2:0]           sub_r;
  logic signed [SW-1:0] prod_r;
  logic signed [SW-1:0] len2_r, dot_r, cr_r, lhs_r, uu_r, vv_r;
  logic [QW-1:0]  rem_r, quo_r, num_r;
  logic [CNT-1:0] dcnt_r;
  logic [QW-1:0]  best_r, dist_r;
  logic [7:0]     near_r;
  logic           inside_r, onwall_r, first_r;
  ppl_rsp_t       rsp_r;
  logic           out_valid_r;
  logic [1:0]     acc_status;

  function automatic logic signed [COORD_WIDTH-1:0] cf(input logic [FIELD_W-1:0] f);
    cf = COORD_WIDTH'(signed'(f));
  endfunction

  assign in_ch.ready    = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = rsp_r;

  wire accept = in_ch.valid && in_ch.ready;

  // shared multiplier: one product per cycle
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_M0:    begin mul_a = dx_r; mul_b = dx_r; end
      S_M1:    begin mul_a = dy_r; mul_b = dy_r; end
      S_M2:    begin mul_a = ux_r; mul_b = dx_r; end
      S_M3:    begin mul_a = uy_r; mul_b = dy_r; end
      S_M4:    begin mul_a = dx_r; mul_b = uy_r; end
      S_M5: begin
        case (sub_r)
          3'd0:    begin mul_a = dy_r; mul_b = ux_r; end
          3'd1:    begin mul_a = ux_r; mul_b = ux_r; end
          3'd2:    begin mul_a = uy_r; mul_b = uy_r; end
          3'd3:    begin mul_a = vx_r; mul_b = vx_r; end
          3'd4:    begin mul_a = vy_r; mul_b = vy_r; end
          3'd5:    begin mul_a = uy_r; mul_b = dx_r; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  logic signed [PW-1:0] mul_p;
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  logic [QW-1:0] rem_sh;
  logic [QW:0]   rem_try;
  assign rem_sh  = {rem_r[QW-2:0], num_r[QW-1]};
  assign rem_try = {1'b0, rem_sh} - {1'b0, QW'(unsigned'(len2_r))};

  logic dot_le0;
  assign dot_le0 = dot_r[SW-1] || (dot_r == '0);

  logic signed [SW-1:0] rhs_w;
  logic                 cross_w;
  logic signed [DW-1:0] eay, eby;
  assign eay   = DW'(signed'(rd_r[3*COORD_WIDTH-1 -: COORD_WIDTH]));
  assign eby   = DW'(signed'(rd_r[COORD_WIDTH-1:0]));
  assign rhs_w = SW'(prod_r);   // holds ux*dy from step M5 extra pass
  assign cross_w = (dy_r != '0) && ((eay > DW'(py_r)) != (eby > DW'(py_r))) &&
                   (!dy_r[DW-1] ? (lhs_r > rhs_w) : (lhs_r < rhs_w));

  logic signed [SW-1:0] crabs_w;
  logic [MW-1:0]        abscr;
  assign crabs_w = cr_r[SW-1] ? -cr_r : cr_r;
  assign abscr   = crabs_w[MW-1:0];

  always_comb begin
    acc_status = ST_OK;
    case (in_ch.payload.action)
      ACT_LOAD:  if (count_r >= CW'(MAX_EDGES)) acc_status = ST_FULL;
      ACT_QUERY: if (count_r == '0) acc_status = ST_EMPTY;
      default:   acc_status = ST_OK;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) begin
        if (in_ch.payload.action == ACT_QUERY && count_r != '0) state_nxt = S_RD;
        else state_nxt = S_OUT;
      end
      S_RD:   state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_M0;
      S_M0:   state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_M3;
      S_M3:   state_nxt = S_M4;
      S_M4:   state_nxt = S_M5;
      S_M5:   state_nxt = (sub_r == 3'd5) ? S_DIV : S_M5;
      S_DIV:  state_nxt = (dcnt_r == '0) ? S_EVAL : S_DIV;
      S_EVAL: state_nxt = (CW'(idx_r) + CW'(1) == count_r) ? S_OUT : S_RD;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      tol_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) tol_r <= cfg_wdata;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (state_r == S_OUT) out_valid_r <= 1'b1;
      if (accept) begin
        rsp_r.location     <= LOC_OUTSIDE;
        rsp_r.nearest_edge <= '0;
        rsp_r.status       <= acc_status;
        case (in_ch.payload.action)
          ACT_CLEAR: count_r <= '0;
          ACT_LOAD:  if (acc_status == ST_OK) count_r <= count_r + CW'(1);
          default: ;
        endcase
      end
      if (state_r == S_OUT) begin
        rsp_r.edges_held <= 9'(count_r);
        if (rsp_r.status == ST_OK && first_r == 1'b0) begin
          rsp_r.location     <= onwall_r ? LOC_ON_WALL : (inside_r ? LOC_INSIDE : LOC_OUTSIDE);
          rsp_r.nearest_edge <= near_r;
        end
      end
    end
  end

  // edge store
  always_ff @(posedge clk) begin
    if (accept && in_ch.payload.action == ACT_LOAD && count_r < CW'(MAX_EDGES))
      mem[count_r[AW-1:0]] <= {cf(in_ch.payload.edge_start_x), cf(in_ch.payload.edge_start_y),
                               cf(in_ch.payload.edge_end_x), cf(in_ch.payload.edge_end_y)};
    if (state_r == S_RD) rd_r <= mem[idx_r];
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        idx_r    <= '0;
        px_r     <= cf(in_ch.payload.query_x);
        py_r     <= cf(in_ch.payload.query_y);
        inside_r <= 1'b0;
        onwall_r <= 1'b0;
        first_r  <= 1'b1;
        near_r   <= '0;
      end
      S_DIFF: begin
        dx_r <= DW'(signed'(rd_r[COORD_WIDTH +: COORD_WIDTH])) - DW'(signed'(rd_r[4*COORD_WIDTH-1 -: COORD_WIDTH]));
        dy_r <= eby - eay;
        ux_r <= DW'(px_r) - DW'(signed'(rd_r[4*COORD_WIDTH-1 -: COORD_WIDTH]));
        uy_r <= DW'(py_r) - eay;
        vx_r <= DW'(px_r) - DW'(signed'(rd_r[COORD_WIDTH +: COORD_WIDTH]));
        vy_r <= DW'(py_r) - eby;
        sub_r <= '0;
      end
      S_M0: prod_r <= SW'(mul_p);
      S_M1: len2_r <= prod_r + SW'(mul_p);
      S_M2: prod_r <= SW'(mul_p);
      S_M3: dot_r  <= prod_r + SW'(mul_p);
      S_M4: prod_r <= SW'(mul_p);
      S_M5: begin
        sub_r <= sub_r + 3'd1;
        case (sub_r)
          3'd0: begin cr_r <= prod_r - SW'(mul_p); prod_r <= SW'(mul_p); end
          3'd1: uu_r <= SW'(mul_p);
          3'd2: uu_r <= uu_r + SW'(mul_p);
          3'd3: vv_r <= SW'(mul_p);
          3'd4: vv_r <= vv_r + SW'(mul_p);
          3'd5: begin
            lhs_r  <= SW'(mul_p);
            num_r  <= QW'(abscr) * QW'(abscr);
            rem_r  <= '0;
            quo_r  <= '0;
            dcnt_r <= CNT'(QW);
          end
          default: ;
        endcase
      end
      S_DIV: begin
        if (len2_r == '0 || dot_le0 || dot_r >= len2_r) dcnt_r <= '0;
        else if (dcnt_r != '0) begin
          num_r  <= {num_r[QW-2:0], 1'b0};
          if (!rem_try[QW]) begin
            rem_r <= rem_try[QW-1:0];
            quo_r <= {quo_r[QW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[QW-2:0], 1'b0};
          end
          dcnt_r <= dcnt_r - CNT'(1);
        end
      end
      S_EVAL: begin
        idx_r <= idx_r + AW'(1);
        first_r <= 1'b0;
        if (first_r || dist_r < best_r) begin
          best_r <= dist_r;
          near_r <= 8'(idx_r);
        end
        if (dist_r <= QW'(tol_r)) onwall_r <= 1'b1;
        if (cross_w) inside_r <= !inside_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (len2_r == '0 || dot_le0)     dist_r = QW'(unsigned'(uu_r));
    else if (dot_r >= len2_r)        dist_r = QW'(unsigned'(vv_r));
    else                             dist_r = quo_r + QW'(rem_r != '0);
  end

  // ux*dy for the crossing compare is held in prod_r after the M5 pass
endmodule

// File: rtl/ppl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppl_checker
// Port-level checks of the polygon point locator, bound to the top level.
// ----------------------------------------------------------------------------
`include "polygon_point_locator_unit_defines.svh"
module ppl_checker
  import ppl_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [8:0] edges_held,
  input logic [1:0] status,
  input logic [1:0] location
);
  `PPL_ASSERT(a_no_accept_while_busy, out_valid |-> !in_ready, "request taken with result pending")
  `PPL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(edges_held), "result dropped")
  `PPL_ASSERT(a_status_loc, out_valid && status != ST_OK |-> location == LOC_OUTSIDE, "bad location on error")
  `PPL_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result after reset")
endmodule

bind polygon_point_locator_unit ppl_checker u_ppl_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .edges_held(out_ch.payload.edges_held), .status(out_ch.payload.status),
  .location(out_ch.payload.location)
);

// File: tb/sv/ppl_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppl_result_checker
// Watches the request, result and register ports of the polygon point
// locator. Keeps its own wall table, predicts one result per request and
// compares each result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module ppl_result_checker
  import ppl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  ppl_req_if               req_ch,
  ppl_rsp_if               rsp_ch,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_wdata,
  output int               mismatch_cnt,
  output int               results_owed
);
  typedef struct {
    longint ax, ay, bx, by;
  } wall_t;

  wall_t          walls[MAX_EDGES_DEF];
  int unsigned    wall_cnt;
  logic [TOL_W-1:0] tol_sq;
  ppl_rsp_t       owed_q[$];

  assign results_owed = owed_q.size();

  function automatic longint sx(logic [FIELD_W-1:0] v);
    return longint'($signed(v));
  endfunction

  // squared point-to-segment distance, rounded up
  function automatic logic [63:0] wall_dist_sq(wall_t w, longint px, longint py);
    longint dx, dy, ux, uy, vx, vy, len2, dot, cr;
    logic [63:0]  mag;
    logic [127:0] m2, quo, den;
    dx = w.bx - w.ax;
    dy = w.by - w.ay;
    ux = px - w.ax;
    uy = py - w.ay;
    vx = px - w.bx;
    vy = py - w.by;
    len2 = dx * dx + dy * dy;
    dot  = ux * dx + uy * dy;
    if (len2 == 0 || dot <= 0) return 64'(ux * ux + uy * uy);
    if (dot >= len2) return 64'(vx * vx + vy * vy);
    cr  = dx * uy - dy * ux;
    mag = (cr < 0) ? 64'(-cr) : 64'(cr);
    m2  = {64'd0, mag} * {64'd0, mag};
    den = {64'd0, 64'(len2)};
    quo = m2 / den;
    if (quo * den != m2) quo = quo + 1;
    return quo[63:0];
  endfunction

  function automatic bit ray_hits(wall_t w, longint px, longint py);
    longint dy, lhs, rhs;
    dy = w.by - w.ay;
    if (dy == 0) return 0;
    if ((w.ay > py) == (w.by > py)) return 0;
    lhs = (py - w.ay) * (w.bx - w.ax);
    rhs = (px - w.ax) * dy;
    return (dy > 0) ? (lhs > rhs) : (lhs < rhs);
  endfunction

  function automatic ppl_rsp_t locate_point(ppl_req_t r);
    ppl_rsp_t    res;
    logic [63:0] d, best;
    bit          in_poly, on_wall;
    longint      px, py;
    res = '0;
    in_poly = 0;
    on_wall = 0;
    best = '0;
    case (r.action)
      ACT_CLEAR: wall_cnt = 0;
      ACT_LOAD: begin
        if (wall_cnt >= MAX_EDGES_DEF) begin
          res.status = ST_FULL;
        end else begin
          walls[wall_cnt] = '{sx(r.edge_start_x), sx(r.edge_start_y),
                              sx(r.edge_end_x), sx(r.edge_end_y)};
          wall_cnt++;
        end
      end
      ACT_QUERY: begin
        if (wall_cnt == 0) begin
          res.status = ST_EMPTY;
        end else begin
          px = sx(r.query_x);
          py = sx(r.query_y);
          for (int i = 0; i < wall_cnt; i++) begin
            d = wall_dist_sq(walls[i], px, py);
            if (i == 0 || d < best) begin
              best = d;
              res.nearest_edge = 8'(i);
            end
            if (d <= 64'(tol_sq)) on_wall = 1;
            if (ray_hits(walls[i], px, py)) in_poly = !in_poly;
          end
          res.location = on_wall ? LOC_ON_WALL : (in_poly ? LOC_INSIDE : LOC_OUTSIDE);
        end
      end
      default: ;
    endcase
    res.edges_held = 9'(wall_cnt);
    return res;
  endfunction

  always @(posedge clk) begin
    ppl_rsp_t want, got;
    int       errs;
    errs = 0;
    if (!rst_n) begin
      wall_cnt = 0;
      tol_sq   <= '0;
      mismatch_cnt <= 0;
      owed_q.delete();
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.payload;
        if (owed_q.size() == 0) begin
          $error("result with no request waiting: %p", got);
          errs++;
        end else begin
          want = owed_q.pop_front();
          if (got.location !== want.location) begin
            $error("location expected %0d got %0d", want.location, got.location);
            errs++;
          end
          if (got.nearest_edge !== want.nearest_edge) begin
            $error("nearest_edge expected %0d got %0d", want.nearest_edge,
                   got.nearest_edge);
            errs++;
          end
          if (got.edges_held !== want.edges_held) begin
            $error("edges_held expected %0d got %0d", want.edges_held,
                   got.edges_held);
            errs++;
          end
          if (got.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, got.status);
            errs++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) owed_q = {owed_q, locate_point(req_ch.payload)};
      if (cfg_we) tol_sq <= cfg_wdata;
      if (errs != 0) mismatch_cnt <= mismatch_cnt + errs;
    end
  end
endmodule

// File: tb/sv/tb_polygon_point_locator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polygon_point_locator_unit
// Drives wall loads, clears and point queries into the locator, with random
// idling on both sides, a long result stall and several tolerance settings.
// ----------------------------------------------------------------------------
module tb_polygon_point_locator_unit;
  import ppl_pkg::*;

  localparam int IDLE_LIMIT = 400000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [TOL_W-1:0] cfg_wdata;
  int               mismatch_cnt;
  int               results_owed;
  int               send_idle_pct;
  int               recv_stall_pct;
  bit               long_hold;
  int               quiet_cycles;
  longint           vx[16];
  longint           vy[16];

  ppl_req_if req_ch ();
  ppl_rsp_if rsp_ch ();

  polygon_point_locator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ppl_result_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_ch       (req_ch),
    .rsp_ch       (rsp_ch),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .mismatch_cnt (mismatch_cnt),
    .results_owed (results_owed)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold = 0;
  end

  // result side: random stalls, plus one long hold when asked
  always @(posedge clk) begin
    if (long_hold) begin
      rsp_ch.ready <= 1'b0;
      repeat (3000) @(posedge clk);
      long_hold = 0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("polygon_point_locator_unit verification failed");
      $finish;
    end
  end

  function automatic logic [FIELD_W-1:0] rnd_coord();
    return FIELD_W'($urandom());
  endfunction

  function automatic logic [FIELD_W-1:0] clip16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return 16'h8000;
    return FIELD_W'(v);
  endfunction

  task automatic send(ppl_req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic send_wall(longint ax, longint ay, longint bx, longint by);
    ppl_req_t r;
    r = '{action: ACT_LOAD, edge_start_x: clip16(ax), edge_start_y: clip16(ay),
          edge_end_x: clip16(bx), edge_end_y: clip16(by),
          query_x: rnd_coord(), query_y: rnd_coord()};
    send(r);
  endtask

  task automatic send_query(longint px, longint py);
    ppl_req_t r;
    r = '{action: ACT_QUERY, edge_start_x: rnd_coord(), edge_start_y: rnd_coord(),
          edge_end_x: rnd_coord(), edge_end_y: rnd_coord(),
          query_x: clip16(px), query_y: clip16(py)};
    send(r);
  endtask

  task automatic send_action(logic [1:0] act);
    ppl_req_t r;
    r = {act, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
         rnd_coord()};
    send(r);
  endtask

  // hold until every result is back, then write the tolerance
  task automatic set_tolerance(logic [TOL_W-1:0] v);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one random polygon with queries around it; returns requests sent
  task automatic run_polygon(output int sent);
    int     n, nq, k, span;
    longint cx, cy, px, py;
    n = $urandom_range(3, 10);
    nq = $urandom_range(4, 12);
    span = $urandom_range(4, 3000);
    cx = $signed($urandom_range(0, 50000)) - 25000;
    cy = $signed($urandom_range(0, 50000)) - 25000;
    send_action(ACT_CLEAR);
    for (int i = 0; i < n; i++) begin
      vx[i] = cx + $signed($urandom_range(0, 2 * span)) - span;
      vy[i] = cy + $signed($urandom_range(0, 2 * span)) - span;
    end
    for (int i = 0; i < n; i++)
      send_wall(vx[i], vy[i], vx[(i + 1) % n], vy[(i + 1) % n]);
    for (int q = 0; q < nq; q++) begin
      k = $urandom_range(0, n - 1);
      case ($urandom_range(0, 4))
        0: begin px = vx[k]; py = vy[k]; end
        1: begin
          px = (vx[k] + vx[(k + 1) % n]) / 2;
          py = (vy[k] + vy[(k + 1) % n]) / 2;
        end
        2: begin px = cx + $signed($urandom_range(0, 4 * span)) - 2 * span; py = vy[k]; end
        default: begin
          px = cx + $signed($urandom_range(0, 2 * span)) - span;
          py = cy + $signed($urandom_range(0, 2 * span)) - span;
        end
      endcase
      send_query(px, py);
    end
    sent = 1 + n + nq;
  endtask

  initial begin
    int got, phase_items;
    logic [TOL_W-1:0] tol_vals[4];
    int send_pcts[4];
    int recv_pcts[4];
    tol_vals  = '{16'd0, 16'd65535, 16'd64, 16'd1};
    send_pcts = '{0, 69, 0, 32};
    recv_pcts = '{0, 0, 69, 32};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_tolerance(16'd0);

    // directed: empty query, extremes, degenerate and horizontal walls, odd action
    send_query(0, 0);
    send_action(2'd3);
    send_wall(-32768, -32768, 32767, 32767);
    send_wall(32767, 32767, 32767, 32767);
    send_wall(-32768, 32767, 32767, 32767);
    send_wall(32767, -32768, -32768, -32768);
    send_query(32767, 32767);
    send_query(-32768, 32767);
    send_query(0, 0);
    send_query(100, -200);
    send_query(32767, -32768);
    send_action(2'd3);
    send_action(ACT_CLEAR);
    send_query(5, 5);
    send_wall(0, 0, 160, 0);
    send_wall(160, 0, 160, 160);
    send_wall(160, 160, 0, 0);
    send_query(80, 0);
    send_query(120, 40);
    send_query(160, 80);
    send_query(159, 1);
    send_query(-1, 0);
    set_tolerance(16'd65535);
    send_query(170, 80);
    send_query(-32768, -32768);

    // random phases, one idling mode and tolerance each
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = 0;
      set_tolerance(ph == 3 ? 16'($urandom()) : tol_vals[ph]);
      send_idle_pct  = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      phase_items = 0;
      if (ph == 2) long_hold = 1;
      while (phase_items < 185) begin
        if ($urandom_range(99) < 12) begin
          send_action(2'($urandom_range(0, 3)));
          phase_items++;
        end else begin
          run_polygon(got);
          phase_items += got;
        end
      end
    end

    // fill the table to the top, refuse two more loads, query it
    send_action(ACT_CLEAR);
    for (int i = 0; i < MAX_EDGES_DEF + 2; i++)
      send_wall($signed($urandom_range(0, 800)) - 400, $signed($urandom_range(0, 800)) - 400,
                $signed($urandom_range(0, 800)) - 400, $signed($urandom_range(0, 800)) - 400);
    send_query(0, 0);
    send_query($signed(rnd_coord()), $signed(rnd_coord()));
    send_action(ACT_CLEAR);
    send_query(0, 0);

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("polygon_point_locator_unit verification clean");
    else
      $display("polygon_point_locator_unit verification failed");
    $finish;
  end
endmodule

// File: sim.f
+incdir+rtl
rtl/ppl_pkg.sv
rtl/ppl_if.sv
rtl/polygon_point_locator_unit.sv
rtl/ppl_checker.sv
tb/sv/ppl_result_checker.sv
tb/sv/tb_polygon_point_locator_unit.sv
